FILE: rtl/ntcb_pkg.sv
// Types, widths and constants shared by the NTC beta converter.
package ntcb_pkg;

   localparam int NUM_CHANNELS = 3;

   localparam int LOG_STEPS   = 24;
   localparam int DIV_QBITS   = LOG_STEPS;
   localparam int TMP_QBITS   = 17;

   localparam int ST_MUL   = 1;
   localparam int ST_SEL   = 2;
   localparam int ST_PREP  = 3;
   localparam int ST_LZ0   = 4;
   localparam int ST_LZ1   = 5;
   localparam int ST_LZ2   = 6;
   localparam int ST_ITER  = 7;
   localparam int ST_LDIFF = ST_ITER + LOG_STEPS;
   localparam int ST_LNMUL = ST_LDIFF + 1;
   localparam int ST_ROUND = ST_LNMUL + 1;
   localparam int ST_TDEN  = ST_ROUND + 1;
   localparam int ST_TNUM  = ST_TDEN + 1;
   localparam int ST_TOVF  = ST_TNUM + 1;
   localparam int ST_TDIV  = ST_TOVF + 1;
   localparam int NSTAGE   = ST_TDIV + TMP_QBITS;

   localparam logic [31:0] LN2_Q32      = 32'd2977044472;
   localparam int          T25_CENTI_K  = 29815;
   localparam int          ZERO_C_CENTI = 27315;
   localparam int          Q_LIMIT      = 127315;
   localparam int          BETA_SCALE   = 6553600;
   localparam int          BQ_ROUND     = 14907;

   localparam logic signed [17:0] TEMP_MAX = 18'sd100000;
   localparam logic signed [17:0] TEMP_MIN = -18'sd27315;
   localparam logic [23:0]        RES_MAX  = 24'hFFFFFF;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_CHANNEL,
      STATUS_RAIL,
      STATUS_PULLDOWN
   } status_type;

   typedef enum logic [2:0] {
      CSR_BETA,
      CSR_BASE,
      CSR_PULLUP,
      CSR_PULLDOWN,
      CSR_FITTED,
      CSR_FULL_SCALE
   } csr_index_type;

   typedef struct packed {
      logic [3:0]  channel;
      logic [12:0] sample_mv;
   } req_type;

   typedef struct packed {
      logic signed [17:0] temperature_centi;
      logic [23:0]        thermistor_ohms;
      status_type         status;
      logic [3:0]         channel_out;
   } rsp_type;

   typedef logic [32:0]        num0_type;
   typedef logic [36:0]        lim_type;
   typedef logic [56:0]        num_type;
   typedef logic [36:0]        den_type;
   typedef logic [57:0]        rn_type;
   typedef logic [60:0]        dw_type;
   typedef logic [30:0]        mant_type;
   typedef logic [29:0]        log_type;
   typedef logic [36:0]        bnum_type;
   typedef logic [61:0]        pm_type;
   typedef logic [22:0]        lnr_type;
   typedef logic signed [24:0] tden_type;
   typedef logic [23:0]        tdenp_type;
   typedef logic [37:0]        nt_type;
   typedef logic [40:0]        tw_type;
   typedef logic [16:0]        tq_type;

   typedef struct packed {
      logic [63:0] w;
      logic [5:0]  z;
   } lz_type;

   typedef struct packed {
      logic [3:0]  ch;
      logic        bad;
      logic        zero;
      logic        rail;
      logic        beyond;
      logic        nzero;
      num0_type    num0;
      logic [12:0] den0;
      lim_type     lim;
      num_type     num_p;
      num_type     num;
      den_type     den;
      num_type     denb;
      rn_type      res_r;
      logic        res_ovf;
      logic [23:0] res_q;
      lz_type      lza;
      lz_type      lzb;
      mant_type    ma;
      mant_type    mb;
      logic [5:0]  ka;
      logic [5:0]  kb;
      logic [23:0] fa;
      logic [23:0] fb;
      bnum_type    bq_r;
      logic [23:0] bq_q;
      logic        neg;
      log_type     mag;
      pm_type      pm;
      lnr_type     lnr;
      logic        tsat;
      tdenp_type   tdenp;
      nt_type      t_r;
      logic        tovf;
      tq_type      t_q;
   } pipe_type;

endpackage

FILE: rtl/ntc_thermistor_beta_converter_unit.sv
// Top level: pipelined NTC thermistor beta-equation temperature converter.
//
//   channel   direction  handshake                 payload
//   request   in         start, busy               req_data (channel, sample_mv)
//   result    out        rsp_strobe (one cycle)    rsp_data (temp, ohms, status, channel)
//   csr       in         csr_write_enable          csr_index, csr_data
//
// One request is taken every cycle while busy is low; it passes through the pipe_ff
// stages and the registered result stage before its result strobe rises.
// The latency is set by the 24 log2 squaring stages (shared with the resistance
// and beta restoring dividers) and the 17-stage temperature divider.
// Reset is synchronous and clears the valid bits; busy is high only during reset.
// Results cannot be held off, so the pipeline never stalls.
module ntc_thermistor_beta_converter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ntcb_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ntcb_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_data
);

   logic [13:0] beta_ff;
   logic [19:0] base_ff;
   logic [19:0] pullup_ff;
   logic [23:0] pulldown_ff;
   logic        fitted_ff;
   logic [12:0] full_ff;

   ntcb_pkg::bnum_type bnum_ff, bnum_in;

   ntcb_pkg::pipe_type pipe_ff [ntcb_pkg::NSTAGE];
   ntcb_pkg::pipe_type pipe_in [ntcb_pkg::NSTAGE];
   logic [ntcb_pkg::NSTAGE-1:0] valid_ff, valid_in;

   ntcb_pkg::rsp_type rsp_ff, rsp_in;
   logic              strobe_ff, strobe_in;

   function automatic ntcb_pkg::lz_type lz_step(ntcb_pkg::lz_type x, int sh);
      ntcb_pkg::lz_type r;
      r = x;
      if ((x.w >> (64 - sh)) == 64'd0) begin
         r.w = x.w << sh;
         r.z = x.z + 6'(sh);
      end
      return r;
   endfunction

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff     <= 14'd3977;
         base_ff     <= 20'd4700;
         pullup_ff   <= 20'd10000;
         pulldown_ff <= 24'd45000;
         fitted_ff   <= 1'b1;
         full_ff     <= 13'd3300;
      end else if (csr_write_enable) begin
         case (csr_index)
            ntcb_pkg::CSR_BETA:       beta_ff     <= csr_data[13:0];
            ntcb_pkg::CSR_BASE:       base_ff     <= csr_data[19:0];
            ntcb_pkg::CSR_PULLUP:     pullup_ff   <= csr_data[19:0];
            ntcb_pkg::CSR_PULLDOWN:   pulldown_ff <= csr_data;
            ntcb_pkg::CSR_FITTED:     fitted_ff   <= csr_data[0];
            ntcb_pkg::CSR_FULL_SCALE: full_ff     <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   assign bnum_in = ntcb_pkg::bnum_type'(beta_ff)
                  * ntcb_pkg::bnum_type'(ntcb_pkg::BETA_SCALE);

   // entry: divider numerator, rail and channel checks
   always_comb begin
      ntcb_pkg::pipe_type p;
      p        = '0;
      p.ch     = req_data.channel;
      p.bad    = {1'b0, req_data.channel} >= 5'(ntcb_pkg::NUM_CHANNELS);
      p.zero   = req_data.sample_mv == 13'd0;
      p.rail   = req_data.sample_mv >= full_ff;
      p.num0   = ntcb_pkg::num0_type'(req_data.sample_mv)
               * ntcb_pkg::num0_type'(pullup_ff);
      p.den0   = full_ff - req_data.sample_mv;
      p.nzero  = 1'b0;
      pipe_in[0] = p;
   end

   for (genvar i = 1; i < ntcb_pkg::NSTAGE; i++) begin : g_stage
      if (i == ntcb_pkg::ST_MUL) begin : g_mul
         always_comb begin
            ntcb_pkg::pipe_type p;
            p       = pipe_ff[i-1];
            p.lim   = ntcb_pkg::lim_type'(pulldown_ff) * ntcb_pkg::lim_type'(p.den0);
            p.num_p = ntcb_pkg::num_type'(p.num0) * ntcb_pkg::num_type'(pulldown_ff);
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_SEL) begin : g_sel
         always_comb begin
            ntcb_pkg::pipe_type p;
            p = pipe_ff[i-1];
            if (fitted_ff) begin
               p.beyond = ntcb_pkg::lim_type'(p.num0) >= p.lim;
               p.den    = p.lim - ntcb_pkg::lim_type'(p.num0);
               p.num    = p.num_p;
            end else begin
               p.beyond = 1'b0;
               p.den    = ntcb_pkg::den_type'(p.den0);
               p.num    = ntcb_pkg::num_type'(p.num0);
            end
            p.nzero = p.num0 == '0;
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_PREP) begin : g_prep
         always_comb begin
            ntcb_pkg::pipe_type p;
            logic [19:0]        base_eff;
            p        = pipe_ff[i-1];
            base_eff = (base_ff == 20'd0) ? 20'd1 : base_ff;
            p.denb   = ntcb_pkg::num_type'(p.den) * ntcb_pkg::num_type'(base_eff);
            p.res_r  = ntcb_pkg::rn_type'(p.num) + ntcb_pkg::rn_type'(p.den >> 1);
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_LZ0) begin : g_lz0
         always_comb begin
            ntcb_pkg::pipe_type p;
            ntcb_pkg::lz_type   a;
            ntcb_pkg::lz_type   b;
            p         = pipe_ff[i-1];
            a.w       = {7'd0, p.num};
            a.z       = 6'd0;
            b.w       = {7'd0, p.denb};
            b.z       = 6'd0;
            p.lza     = lz_step(lz_step(a, 32), 16);
            p.lzb     = lz_step(lz_step(b, 32), 16);
            p.res_ovf = ntcb_pkg::dw_type'(p.res_r)
                      >= (ntcb_pkg::dw_type'(p.den) << ntcb_pkg::DIV_QBITS);
            p.bq_r    = bnum_ff + ntcb_pkg::bnum_type'(ntcb_pkg::BQ_ROUND);
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_LZ1) begin : g_lz1
         always_comb begin
            ntcb_pkg::pipe_type p;
            p     = pipe_ff[i-1];
            p.lza = lz_step(lz_step(p.lza, 8), 4);
            p.lzb = lz_step(lz_step(p.lzb, 8), 4);
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_LZ2) begin : g_lz2
         always_comb begin
            ntcb_pkg::pipe_type p;
            ntcb_pkg::lz_type   a;
            ntcb_pkg::lz_type   b;
            p       = pipe_ff[i-1];
            a       = lz_step(lz_step(p.lza, 2), 1);
            b       = lz_step(lz_step(p.lzb, 2), 1);
            p.lza   = a;
            p.lzb   = b;
            p.ma    = a.w[63:33];
            p.mb    = b.w[63:33];
            p.ka    = 6'd63 - a.z;
            p.kb    = 6'd63 - b.z;
            p.fa    = '0;
            p.fb    = '0;
            p.res_q = '0;
            p.bq_q  = '0;
            pipe_in[i] = p;
         end
      end else if (i < ntcb_pkg::ST_LDIFF) begin : g_iter
         localparam int QB = ntcb_pkg::DIV_QBITS - 1 - (i - ntcb_pkg::ST_ITER);
         always_comb begin
            ntcb_pkg::pipe_type p;
            logic [61:0]        sqa;
            logic [61:0]        sqb;
            ntcb_pkg::dw_type   dr;
            ntcb_pkg::dw_type   db;
            p   = pipe_ff[i-1];
            sqa = 62'(p.ma) * 62'(p.ma);
            sqb = 62'(p.mb) * 62'(p.mb);
            if (sqa[61]) begin
               p.ma = sqa[61:31];
               p.fa = {p.fa[22:0], 1'b1};
            end else begin
               p.ma = sqa[60:30];
               p.fa = {p.fa[22:0], 1'b0};
            end
            if (sqb[61]) begin
               p.mb = sqb[61:31];
               p.fb = {p.fb[22:0], 1'b1};
            end else begin
               p.mb = sqb[60:30];
               p.fb = {p.fb[22:0], 1'b0};
            end
            dr = ntcb_pkg::dw_type'(p.den) << QB;
            if (ntcb_pkg::dw_type'(p.res_r) >= dr) begin
               p.res_r     = p.res_r - ntcb_pkg::rn_type'(dr);
               p.res_q[QB] = 1'b1;
            end
            db = ntcb_pkg::dw_type'(ntcb_pkg::T25_CENTI_K) << QB;
            if (ntcb_pkg::dw_type'(p.bq_r) >= db) begin
               p.bq_r     = p.bq_r - ntcb_pkg::bnum_type'(db);
               p.bq_q[QB] = 1'b1;
            end
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_LDIFF) begin : g_ldiff
         always_comb begin
            ntcb_pkg::pipe_type p;
            ntcb_pkg::log_type  la;
            ntcb_pkg::log_type  lb;
            p     = pipe_ff[i-1];
            la    = {p.ka, p.fa};
            lb    = {p.kb, p.fb};
            p.neg = la < lb;
            p.mag = p.neg ? (lb - la) : (la - lb);
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_LNMUL) begin : g_lnmul
         always_comb begin
            ntcb_pkg::pipe_type p;
            p    = pipe_ff[i-1];
            p.pm = ntcb_pkg::pm_type'(p.mag) * ntcb_pkg::pm_type'(ntcb_pkg::LN2_Q32);
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_ROUND) begin : g_round
         always_comb begin
            ntcb_pkg::pipe_type p;
            logic [62:0]        rs;
            p     = pipe_ff[i-1];
            rs    = 63'(p.pm) + (63'd1 << 39);
            p.lnr = rs[62:40];
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_TDEN) begin : g_tden
         always_comb begin
            ntcb_pkg::pipe_type p;
            ntcb_pkg::tden_type td;
            p = pipe_ff[i-1];
            if (p.neg) begin
               td = ntcb_pkg::tden_type'(p.bq_q) - ntcb_pkg::tden_type'(p.lnr);
            end else begin
               td = ntcb_pkg::tden_type'(p.bq_q) + ntcb_pkg::tden_type'(p.lnr);
            end
            p.tsat  = td[24] || (td == '0);
            p.tdenp = td[23:0];
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_TNUM) begin : g_tnum
         always_comb begin
            ntcb_pkg::pipe_type p;
            p     = pipe_ff[i-1];
            p.t_r = ntcb_pkg::nt_type'(bnum_ff) + ntcb_pkg::nt_type'(p.tdenp >> 1);
            pipe_in[i] = p;
         end
      end else if (i == ntcb_pkg::ST_TOVF) begin : g_tovf
         always_comb begin
            ntcb_pkg::pipe_type p;
            p      = pipe_ff[i-1];
            p.tovf = ntcb_pkg::tw_type'(p.t_r)
                   >= (ntcb_pkg::tw_type'(p.tdenp) << ntcb_pkg::TMP_QBITS);
            p.t_q  = '0;
            pipe_in[i] = p;
         end
      end else begin : g_tdiv
         localparam int TB = ntcb_pkg::TMP_QBITS - 1 - (i - ntcb_pkg::ST_TDIV);
         always_comb begin
            ntcb_pkg::pipe_type p;
            ntcb_pkg::tw_type   dt;
            p  = pipe_ff[i-1];
            dt = ntcb_pkg::tw_type'(p.tdenp) << TB;
            if (ntcb_pkg::tw_type'(p.t_r) >= dt) begin
               p.t_r     = p.t_r - ntcb_pkg::nt_type'(dt);
               p.t_q[TB] = 1'b1;
            end
            pipe_in[i] = p;
         end
      end
   end

   assign valid_in = {valid_ff[ntcb_pkg::NSTAGE-2:0], start & ~busy};

   // result selection: special cases take priority over the computed values
   always_comb begin
      ntcb_pkg::pipe_type  p;
      logic signed [17:0]  tc;
      logic [23:0]         rc;
      p  = pipe_ff[ntcb_pkg::NSTAGE-1];
      rc = p.res_ovf ? ntcb_pkg::RES_MAX : p.res_q;
      if (p.tsat || p.tovf || (p.t_q > ntcb_pkg::tq_type'(ntcb_pkg::Q_LIMIT))) begin
         tc = ntcb_pkg::TEMP_MAX;
      end else begin
         tc = signed'(18'(p.t_q) - 18'(ntcb_pkg::ZERO_C_CENTI));
      end
      rsp_in.channel_out = p.ch;
      if (p.bad) begin
         rsp_in.temperature_centi = 18'sd0;
         rsp_in.thermistor_ohms   = 24'd0;
         rsp_in.status            = ntcb_pkg::STATUS_BAD_CHANNEL;
      end else if (p.zero) begin
         rsp_in.temperature_centi = ntcb_pkg::TEMP_MAX;
         rsp_in.thermistor_ohms   = 24'd0;
         rsp_in.status            = ntcb_pkg::STATUS_RAIL;
      end else if (p.rail) begin
         rsp_in.temperature_centi = ntcb_pkg::TEMP_MIN;
         rsp_in.thermistor_ohms   = ntcb_pkg::RES_MAX;
         rsp_in.status            = ntcb_pkg::STATUS_RAIL;
      end else if (p.beyond) begin
         rsp_in.temperature_centi = ntcb_pkg::TEMP_MIN;
         rsp_in.thermistor_ohms   = ntcb_pkg::RES_MAX;
         rsp_in.status            = ntcb_pkg::STATUS_PULLDOWN;
      end else if (p.nzero) begin
         rsp_in.temperature_centi = ntcb_pkg::TEMP_MAX;
         rsp_in.thermistor_ohms   = 24'd0;
         rsp_in.status            = ntcb_pkg::STATUS_OK;
      end else begin
         rsp_in.temperature_centi = tc;
         rsp_in.thermistor_ohms   = rc;
         rsp_in.status            = ntcb_pkg::STATUS_OK;
      end
   end

   assign strobe_in = valid_ff[ntcb_pkg::NSTAGE-1];

   always_ff @(posedge clock) begin
      bnum_ff <= bnum_in;
      pipe_ff <= pipe_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ntcb_pkg::NSTAGE + 1) rsp_strobe)
      else $error("request did not produce a result at the pipeline depth");

   a_bad_channel : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.status == ntcb_pkg::STATUS_BAD_CHANNEL)
                      == ({1'b0, rsp_data.channel_out} >= 5'(ntcb_pkg::NUM_CHANNELS))))
      else $error("bad-channel status disagrees with echoed channel");

   a_temp_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == ntcb_pkg::STATUS_OK)
      |-> (rsp_data.temperature_centi >= ntcb_pkg::TEMP_MIN
           && rsp_data.temperature_centi <= ntcb_pkg::TEMP_MAX))
      else $error("temperature outside saturation range");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the NTC thermistor beta-equation converter.
`timescale 1ns / 1ps

module testbench;

   localparam int LATENCY = 54;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   ntcb_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   ntcb_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [23:0]       csr_data = '0;

   logic [13:0] beta_k;
   logic [19:0] base_ohm;
   logic [19:0] pullup_ohm;
   logic [23:0] pulldown_ohm;
   logic        pulldown_on;
   logic [12:0] full_scale;

   ntcb_pkg::rsp_type pending_temps[$];
   int                errors = 0;
   int                requests_sent = 0;
   int                results_checked = 0;
   int                idle_pct = 0;

   ntc_thermistor_beta_converter_unit dut (.*);

   always #10 clock = ~clock;

   function automatic longint log2_q24(input logic [63:0] x);
      int          k;
      logic [63:0] m;
      logic [63:0] frac;
      if (x == 0) return 0;
      k = 63;
      frac = 0;
      while (k > 0 && x[k] == 1'b0) k--;
      if (k >= 30) m = x >> (k - 30);
      else m = x << (30 - k);
      for (int i = 0; i < ntcb_pkg::LOG_STEPS; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return longint'((64'(k) << 24) | frac);
   endfunction

   function automatic ntcb_pkg::rsp_type convert_sample(input ntcb_pkg::req_type r);
      ntcb_pkg::rsp_type o;
      logic [63:0]       num, den, lim, res, base, bnum, bq, q, mag;
      longint            ldiff, p, lnr, tden, t;
      o.channel_out = r.channel;
      o.status = ntcb_pkg::STATUS_OK;
      if (r.channel >= ntcb_pkg::NUM_CHANNELS) begin
         o.status = ntcb_pkg::STATUS_BAD_CHANNEL;
         o.temperature_centi = 18'sd0;
         o.thermistor_ohms = 24'd0;
         return o;
      end
      if (r.sample_mv == 0) begin
         o.status = ntcb_pkg::STATUS_RAIL;
         o.temperature_centi = ntcb_pkg::TEMP_MAX;
         o.thermistor_ohms = 24'd0;
         return o;
      end
      if (r.sample_mv >= full_scale) begin
         o.status = ntcb_pkg::STATUS_RAIL;
         o.temperature_centi = ntcb_pkg::TEMP_MIN;
         o.thermistor_ohms = ntcb_pkg::RES_MAX;
         return o;
      end
      num = 64'(r.sample_mv) * 64'(pullup_ohm);
      den = 64'(full_scale) - 64'(r.sample_mv);
      if (pulldown_on) begin
         lim = 64'(pulldown_ohm) * den;
         if (num >= lim) begin
            o.status = ntcb_pkg::STATUS_PULLDOWN;
            o.temperature_centi = ntcb_pkg::TEMP_MIN;
            o.thermistor_ohms = ntcb_pkg::RES_MAX;
            return o;
         end
         den = lim - num;
         num = num * 64'(pulldown_ohm);
      end
      if (num == 0) begin
         o.temperature_centi = ntcb_pkg::TEMP_MAX;
         o.thermistor_ohms = 24'd0;
         return o;
      end
      res = (num + den / 2) / den;
      if (res > 64'(ntcb_pkg::RES_MAX)) res = 64'(ntcb_pkg::RES_MAX);
      o.thermistor_ohms = res[23:0];
      base = (base_ohm == 0) ? 64'd1 : 64'(base_ohm);
      ldiff = log2_q24(num) - log2_q24(den * base);
      p = ldiff * longint'(ntcb_pkg::LN2_Q32);
      if (p >= 0) lnr = longint'((64'(p) + (64'd1 << 39)) >> 40);
      else begin
         mag = 64'(-p);
         lnr = -longint'((mag + (64'd1 << 39)) >> 40);
      end
      bnum = 64'(beta_k) * 64'(ntcb_pkg::BETA_SCALE);
      bq = (bnum + 64'(ntcb_pkg::BQ_ROUND)) / 64'(ntcb_pkg::T25_CENTI_K);
      tden = lnr + longint'(bq);
      if (tden <= 0) t = 100000;
      else begin
         q = (bnum + 64'(tden) / 2) / 64'(tden);
         if (q > 64'(ntcb_pkg::Q_LIMIT)) t = 100000;
         else t = longint'(q) - ntcb_pkg::ZERO_C_CENTI;
      end
      o.temperature_centi = 18'(t);
      return o;
   endfunction

   task automatic write_csr(input ntcb_pkg::csr_index_type idx, input logic [23:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         ntcb_pkg::CSR_BETA:       beta_k = value[13:0];
         ntcb_pkg::CSR_BASE:       base_ohm = value[19:0];
         ntcb_pkg::CSR_PULLUP:     pullup_ohm = value[19:0];
         ntcb_pkg::CSR_PULLDOWN:   pulldown_ohm = value;
         ntcb_pkg::CSR_FITTED:     pulldown_on = value[0];
         ntcb_pkg::CSR_FULL_SCALE: full_scale = value[12:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [13:0] b, input logic [19:0] r25,
                            input logic [19:0] rpu, input logic [23:0] rpd,
                            input logic fit, input logic [12:0] fs);
      write_csr(ntcb_pkg::CSR_BETA, 24'(b));
      write_csr(ntcb_pkg::CSR_BASE, 24'(r25));
      write_csr(ntcb_pkg::CSR_PULLUP, 24'(rpu));
      write_csr(ntcb_pkg::CSR_PULLDOWN, rpd);
      write_csr(ntcb_pkg::CSR_FITTED, 24'(fit));
      write_csr(ntcb_pkg::CSR_FULL_SCALE, 24'(fs));
   endtask

   // start stays high across back-to-back requests; it is lowered only on an idle cycle or in drain
   task automatic send_request(input logic [3:0] ch, input logic [12:0] mv);
      while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{channel: ch, sample_mv: mv};
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_temps.push_back(convert_sample('{channel: ch, sample_mv: mv}));
      requests_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_temps.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_temps.size() == 0) begin
            $error("unexpected result for channel %0d", rsp_data.channel_out);
            errors++;
         end else begin
            ntcb_pkg::rsp_type e;
            e = pending_temps.pop_front();
            results_checked++;
            if (rsp_data.temperature_centi !== e.temperature_centi) begin
               $error("temperature_centi: expected %0d, got %0d",
                      e.temperature_centi, rsp_data.temperature_centi);
               errors++;
            end
            if (rsp_data.thermistor_ohms !== e.thermistor_ohms) begin
               $error("thermistor_ohms: expected %0d, got %0d",
                      e.thermistor_ohms, rsp_data.thermistor_ohms);
               errors++;
            end
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.channel_out !== e.channel_out) begin
               $error("channel_out: expected %0d, got %0d",
                      e.channel_out, rsp_data.channel_out);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      configure(14'd3977, 20'd4700, 20'd10000, 24'd45000, 1'b1, 13'd3300);
      send_request(4'd0, 13'd0);
      send_request(4'd1, 13'd1);
      send_request(4'd2, 13'd1650);
      send_request(4'd0, 13'd3299);
      send_request(4'd1, 13'd3300);
      send_request(4'd2, 13'h1FFF);
      send_request(4'd3, 13'd1000);
      send_request(4'd15, 13'd1000);
      send_request(4'd0, 13'd2900);
      send_request(4'd1, 13'd2500);
      drain();
      // no pull-down, tiny base, extreme beta
      configure(14'd10000, 20'd0, 20'd1, 24'd0, 1'b0, 13'd5000);
      send_request(4'd0, 13'd1);
      send_request(4'd1, 13'd4999);
      send_request(4'd2, 13'd2500);
      drain();
      configure(14'd1000, 20'd1000000, 20'd1000000, 24'd10000000, 1'b1, 13'd1);
      send_request(4'd0, 13'd0);
      send_request(4'd1, 13'd1);
      drain();
      // zero pull-down fitted, zero pull-up, zero full scale
      configure(14'h3FFF, 20'hFFFFF, 20'd0, 24'd0, 1'b1, 13'd0);
      send_request(4'd0, 13'd5);
      drain();
      configure(14'h3FFF, 20'hFFFFF, 20'd0, 24'hFFFFFF, 1'b1, 13'h1FFF);
      send_request(4'd1, 13'd100);
      send_request(4'd2, 13'h1FFE);
      drain();
   endtask

   task automatic test_random(input int count, input int pct);
      idle_pct = pct;
      for (int i = 0; i < count; i++) begin
         logic [3:0]  ch;
         logic [12:0] mv;
         ch = ($urandom_range(9, 0) == 0) ? 4'($urandom) : 4'($urandom_range(2, 0));
         case ($urandom_range(9, 0))
            0:       mv = 13'($urandom);
            1:       mv = 13'($urandom_range(3, 0));
            default: mv = (full_scale > 1) ? 13'($urandom_range(full_scale - 1, 1))
                                           : 13'($urandom);
         endcase
         send_request(ch, mv);
      end
      idle_pct = 0;
      drain();
   endtask

   task automatic test_settings();
      configure(14'($urandom_range(10000, 1000)), 20'($urandom_range(1000000, 1)),
                20'($urandom_range(1000000, 1)), 24'($urandom_range(10000000, 1)),
                1'($urandom), 13'($urandom_range(5000, 1)));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      pulldown_on = 1'b1;
      @(posedge clock);
      test_directed();
      configure(14'd3977, 20'd4700, 20'd10000, 24'd45000, 1'b1, 13'd3300);
      test_random(150, 0);
      test_settings();
      test_random(150, 71);
      test_settings();
      test_random(150, 21);
      configure(14'd3435, 20'd10000, 20'd10000, 24'd0, 1'b0, 13'd3300);
      test_random(100, 0);
      configure(14'd4250, 20'd100000, 20'd47000, 24'd200000, 1'b1, 13'd5000);
      test_random(100, 71);
      $display("covered %0d requests and %0d results over several coefficient sets",
               requests_sent, results_checked);
      if (errors == 0) $display("ntc_thermistor_beta_converter_unit verification clean");
      else $display("ntc_thermistor_beta_converter_unit verification failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("ntc_thermistor_beta_converter_unit verification failed");
      $finish;
   end

endmodule
